>>> rtl/core/bbc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the 3x3 box blur core.
package bbc_pkg;

    localparam int CHAN_W      = 8;
    localparam int PIX_W       = 3 * CHAN_W;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_W    = 16;
    localparam int ROW_W       = HEIGHT_W + 1;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [WIDTH_REG_W-1:0] RESET_IMAGE_WIDTH  = 11'd640;
    localparam logic [HEIGHT_W-1:0]    RESET_IMAGE_HEIGHT = 16'd480;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam int DEF_MAX_ROW_PIXELS = 1024;
    localparam int OP_QUEUE_DEPTH     = 4;
    localparam int OUT_QUEUE_DEPTH    = 4;

    localparam int CNT_W       = 4;
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = SUM_W + RECIP_W;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             emit;
        logic             last;
        logic             top;
        logic             bottom;
        logic             left;
        logic             right;
        logic [CNT_W-1:0] n;
    } op_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              frame_end;
    } result_t;

    function automatic logic [CNT_W-1:0] pixel_count(input logic top, input logic bottom,
                                                     input logic left, input logic right);
        logic [CNT_W-1:0] rows;
        logic [CNT_W-1:0] cols;
        rows = CNT_W'(1) + CNT_W'(top) + CNT_W'(bottom);
        cols = CNT_W'(1) + CNT_W'(left) + CNT_W'(right);
        return CNT_W'(rows * cols);
    endfunction

    // Rounded-up reciprocal 2^16 / n; exact for every sum that n pixels can give.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd6:    r = 17'd10923;
            4'd9:    r = 17'd7282;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/bbc_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/bbc_fifo.sv
`timescale 1ns / 1ps
// Small synchronous queue in flip-flops with push/full and pop/empty sides.
module bbc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/bbc_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, frame position counters and item classification.
module bbc_front #(
    parameter int MAX_ROW_PIXELS = bbc_pkg::DEF_MAX_ROW_PIXELS,
    localparam int COL_W = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           push,
    input  logic                           cmd,
    input  logic [bbc_pkg::CHAN_W-1:0]     red_in,
    input  logic [bbc_pkg::CHAN_W-1:0]     green_in,
    input  logic [bbc_pkg::CHAN_W-1:0]     blue_in,
    output logic                           full,
    output logic                           op_push,
    output bbc_pkg::op_t                   op,
    output logic [COL_W-1:0]               op_col,
    input  logic                           op_full
);

    import bbc_pkg::*;

    localparam int W_W = $clog2(MAX_ROW_PIXELS + 1);

    logic [WIDTH_REG_W-1:0] width_reg;
    logic [HEIGHT_W-1:0]    height_reg;
    logic [COL_W-1:0]       in_col_reg, in_col_next;
    logic [ROW_W-1:0]       in_row_reg, in_row_next;
    logic [COL_W-1:0]       out_col_reg, out_col_next;
    logic [HEIGHT_W-1:0]    out_row_reg, out_row_next;
    logic [1:0]             pend_reg, pend_next;

    logic [W_W-1:0]      w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [W_W-1:0]      in_col_inc;
    logic [W_W-1:0]      out_col_inc;
    logic                inputs_done;
    logic                win_ready;
    logic                take;
    logic                emit;
    logic                top, bottom, left, right, last;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = W_W'(1);
        end
        else if (32'(width_reg) > MAX_ROW_PIXELS)
        begin
            w_eff = W_W'(MAX_ROW_PIXELS);
        end
        else
        begin
            w_eff = W_W'(width_reg);
        end
    end

    assign h_eff       = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    assign inputs_done = (in_row_reg >= ROW_W'(h_eff));
    assign win_ready   = (in_row_reg >= ROW_W'(2)) ||
                         ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));

    // While a drain tick still needs extra shifts, no new item is taken.
    assign full = op_full || (pend_reg != 2'd0);
    assign take = push && !full;

    always_comb
    begin
        op_push = 1'b0;
        if (pend_reg != 2'd0)
        begin
            op_push = !op_full;
        end
        else if (take)
        begin
            op_push = ((cmd == CMD_PIXEL) && !inputs_done) ||
                      ((cmd == CMD_DRAIN) && inputs_done);
        end
    end

    assign emit        = op_push && win_ready;
    assign in_col_inc  = W_W'(in_col_reg) + 1'b1;
    assign out_col_inc = W_W'(out_col_reg) + 1'b1;
    assign top         = (out_row_reg != '0);
    assign bottom      = (ROW_W'(out_row_reg) + 1'b1) < ROW_W'(h_eff);
    assign left        = (out_col_reg != '0);
    assign right       = (out_col_inc < w_eff);
    assign last        = !bottom && !right;

    always_comb
    begin
        op.pix    = ((pend_reg != 2'd0) || (cmd == CMD_DRAIN)) ? '0 : {red_in, green_in, blue_in};
        op.emit   = win_ready;
        op.last   = last;
        op.top    = top;
        op.bottom = bottom;
        op.left   = left;
        op.right  = right;
        op.n      = pixel_count(top, bottom, left, right);
        op_col    = in_col_reg;
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (pend_reg != 2'd0)
        begin
            if (!op_full)
            begin
                pend_next = (win_ready || (pend_reg == 2'd2)) ? 2'd0 : pend_reg + 1'b1;
            end
        end
        else if (take && (cmd == CMD_DRAIN) && inputs_done && !win_ready)
        begin
            pend_next = 2'd1;
        end

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (op_push)
        begin
            if (in_col_inc == w_eff)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end
            else
            begin
                in_col_next = COL_W'(in_col_inc);
            end
            if (emit)
            begin
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (!right)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = COL_W'(out_col_inc);
                end
            end
        end

        // A register write restarts the frame position.
        if (cfg_write)
        begin
            pend_next    = 2'd0;
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= RESET_IMAGE_WIDTH;
            height_reg  <= RESET_IMAGE_HEIGHT;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg    <= 2'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                    default:          ;
                endcase
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

>>> rtl/core/bbc_back.sv
`timescale 1ns / 1ps
// Back end: line memory, 3x3 window, masked sum and reciprocal divide pipeline.
module bbc_back #(
    parameter int MAX_ROW_PIXELS = bbc_pkg::DEF_MAX_ROW_PIXELS,
    localparam int COL_W = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_empty,
    input  bbc_pkg::op_t     op_head,
    input  logic [COL_W-1:0] op_col,
    output logic             op_pop,
    output logic             res_push,
    output bbc_pkg::result_t res,
    input  logic             res_taken
);

    import bbc_pkg::*;

    localparam int CRED_W = $clog2(OUT_QUEUE_DEPTH + 1);
    localparam int PAIR_W = 2 * PIX_W;

    logic [CRED_W-1:0] credit_reg, credit_next;

    logic              a_valid_reg;
    op_t               a_op_reg;
    logic [COL_W-1:0]  a_col_reg;

    logic              fw_valid_reg;
    logic [COL_W-1:0]  fw_col_reg;
    logic [PAIR_W-1:0] fw_data_reg;

    logic [PAIR_W-1:0] ram_rd_data;
    logic [PAIR_W-1:0] pair;
    logic [PAIR_W-1:0] ram_wr_data;

    logic [PIX_W-1:0]  win_reg [3][3];

    logic              c_valid_reg;
    op_t               c_op_reg;

    logic [SUM_W-1:0]  sum [3];
    logic [2:0]        row_on;
    logic [2:0]        col_on;

    logic              d_valid_reg;
    logic [SUM_W-1:0]  d_y_reg [3];
    logic [CNT_W-1:0]  d_n_reg;
    logic              d_last_reg;

    logic              e_valid_reg;
    logic [PROD_W-1:0] e_prod_reg [3];
    logic              e_last_reg;

    // Every emitting op holds a slot in the output queue, so the pipeline never stalls.
    assign op_pop = !op_empty && (!op_head.emit || (credit_reg != '0));

    always_comb
    begin
        credit_next = credit_reg;
        case ({op_pop && op_head.emit, res_taken})
            2'b10:   credit_next = credit_reg - 1'b1;
            2'b01:   credit_next = credit_reg + 1'b1;
            default: credit_next = credit_reg;
        endcase
    end

    bbc_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (MAX_ROW_PIXELS)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (a_valid_reg),
        .wr_addr (a_col_reg),
        .wr_data (ram_wr_data),
        .rd_addr (op_col),
        .rd_data (ram_rd_data)
    );

    // The word written in the previous cycle is not yet visible at the read port.
    assign pair        = (fw_valid_reg && (fw_col_reg == a_col_reg)) ? fw_data_reg : ram_rd_data;
    assign ram_wr_data = {pair[PIX_W-1:0], a_op_reg.pix};

    assign row_on = {c_op_reg.bottom, 1'b1, c_op_reg.top};
    assign col_on = {c_op_reg.right, 1'b1, c_op_reg.left};

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = '0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    if (row_on[i] && col_on[j])
                    begin
                        sum[ch] = sum[ch] +
                                  SUM_W'(win_reg[i][j][PIX_W - CHAN_W * (ch + 1) +: CHAN_W]);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg   <= CRED_W'(OUT_QUEUE_DEPTH);
            a_valid_reg  <= 1'b0;
            fw_valid_reg <= 1'b0;
            c_valid_reg  <= 1'b0;
            d_valid_reg  <= 1'b0;
            e_valid_reg  <= 1'b0;
        end
        else
        begin
            credit_reg   <= credit_next;
            a_valid_reg  <= op_pop;
            fw_valid_reg <= a_valid_reg;
            c_valid_reg  <= a_valid_reg && a_op_reg.emit;
            d_valid_reg  <= c_valid_reg;
            e_valid_reg  <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_op_reg    <= op_head;
        a_col_reg   <= op_col;
        fw_col_reg  <= a_col_reg;
        fw_data_reg <= ram_wr_data;
        c_op_reg    <= a_op_reg;
        if (a_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= pair[PAIR_W-1:PIX_W];
            win_reg[1][2] <= pair[PIX_W-1:0];
            win_reg[2][2] <= a_op_reg.pix;
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            d_y_reg[ch]    <= sum[ch] + SUM_W'(c_op_reg.n >> 1);
            e_prod_reg[ch] <= PROD_W'(d_y_reg[ch]) * PROD_W'(recip(d_n_reg));
        end
        d_n_reg    <= c_op_reg.n;
        d_last_reg <= c_op_reg.last;
        e_last_reg <= d_last_reg;
    end

    assign res_push      = e_valid_reg;
    assign res.red       = e_prod_reg[0][RECIP_SHIFT +: CHAN_W];
    assign res.green     = e_prod_reg[1][RECIP_SHIFT +: CHAN_W];
    assign res.blue      = e_prod_reg[2][RECIP_SHIFT +: CHAN_W];
    assign res.frame_end = e_last_reg;

endmodule

>>> rtl/core/box_blur_3x3_border_aware_core.sv
`timescale 1ns / 1ps
// Top level of the border-aware 3x3 box blur core.
// A pixel or drain item is taken in the cycle that push is high and full is low. Items that
// give no result pass at one per clock while the op queue has room, but every item that gives
// a result holds one of four output queue credits from the cycle it leaves the op queue until
// its result is taken. With a result on every item the core therefore has at most four items
// in flight past the op queue, even with pop held high. The first drain tick of a single-row
// frame also holds full high while it makes a second line shift. After its item is accepted, a
// result passes the op queue, then line memory read, window update, masked sum, reciprocal
// multiply and output queue. Results trail the pixel stream by one row plus one pixel, so a
// frame needs width plus one drain ticks after its last pixel (width ticks for a single-row
// frame). The four-entry output queue bounds how many results may wait untaken before the
// core stops taking items. The line memory needs no clearing after reset.
module box_blur_3x3_border_aware_core #(
    parameter int MAX_ROW_PIXELS = bbc_pkg::DEF_MAX_ROW_PIXELS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic                           cmd,
    input  logic [bbc_pkg::CHAN_W-1:0]     red_in,
    input  logic [bbc_pkg::CHAN_W-1:0]     green_in,
    input  logic [bbc_pkg::CHAN_W-1:0]     blue_in,
    output logic                           empty,
    input  logic                           pop,
    output logic [bbc_pkg::CHAN_W-1:0]     red_out,
    output logic [bbc_pkg::CHAN_W-1:0]     green_out,
    output logic [bbc_pkg::CHAN_W-1:0]     blue_out,
    output logic                           frame_end
);

    import bbc_pkg::*;

    localparam int COL_W  = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
    localparam int OP_W   = $bits(op_t);
    localparam int OPQ_W  = OP_W + COL_W;
    localparam int RES_W  = $bits(result_t);

    logic             op_push;
    op_t              front_op;
    logic [COL_W-1:0] front_col;
    logic             op_full;
    logic             op_empty;
    logic             op_pop;
    logic [OPQ_W-1:0] op_q_out;
    op_t              head_op;
    logic [COL_W-1:0] head_col;
    logic             res_push;
    result_t          res;
    result_t          res_head;
    logic             res_taken;

    bbc_front #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .cmd       (cmd),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .full      (full),
        .op_push   (op_push),
        .op        (front_op),
        .op_col    (front_col),
        .op_full   (op_full)
    );

    bbc_fifo #(
        .WIDTH (OPQ_W),
        .DEPTH (OP_QUEUE_DEPTH)
    ) u_op_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (op_push),
        .push_data ({front_op, front_col}),
        .full      (op_full),
        .pop       (op_pop),
        .pop_data  (op_q_out),
        .empty     (op_empty)
    );

    assign head_op  = op_t'(op_q_out[OPQ_W-1:COL_W]);
    assign head_col = op_q_out[COL_W-1:0];

    bbc_back #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_empty  (op_empty),
        .op_head   (head_op),
        .op_col    (head_col),
        .op_pop    (op_pop),
        .res_push  (res_push),
        .res       (res),
        .res_taken (res_taken)
    );

    bbc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .full      (),
        .pop       (pop),
        .pop_data  (res_head),
        .empty     (empty)
    );

    assign res_taken = pop && !empty;
    assign red_out   = res_head.red;
    assign green_out = res_head.green;
    assign blue_out  = res_head.blue;
    assign frame_end = res_head.frame_end;

endmodule

>>> rtl/core/bbc_assert.sv
`timescale 1ns / 1ps
// Port-level assertions for the box blur core and their bind to the top level.
module bbc_assert (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       push,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic [bbc_pkg::CHAN_W-1:0] red_out,
    input logic [bbc_pkg::CHAN_W-1:0] green_out,
    input logic [bbc_pkg::CHAN_W-1:0] blue_out,
    input logic                       frame_end
);

    // A cycle spent in reset leaves both queues empty and nothing pending.
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> (empty && !full))
        else $error("Core not idle during reset.");

    // No result can reach the outputs straight out of reset.
    a_min_latency: assert property (@(posedge clk)
        !empty |-> ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)))
        else $error("Result appeared too soon after reset.");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("Waiting result was dropped.");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(red_out) && $stable(green_out) &&
                              $stable(blue_out) && $stable(frame_end)))
        else $error("Waiting result changed before it was taken.");

endmodule

bind box_blur_3x3_border_aware_core bbc_assert u_bbc_assert (.*);

>>> bench/box_blur_checker.sv
`timescale 1ns / 1ps
// Checker that predicts every blurred pixel of the box blur core and compares it at the output.
module box_blur_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           push,
    input  logic                           full,
    input  logic                           cmd,
    input  logic [bbc_pkg::CHAN_W-1:0]     red_in,
    input  logic [bbc_pkg::CHAN_W-1:0]     green_in,
    input  logic [bbc_pkg::CHAN_W-1:0]     blue_in,
    input  logic                           empty,
    input  logic                           pop,
    input  logic [bbc_pkg::CHAN_W-1:0]     red_out,
    input  logic [bbc_pkg::CHAN_W-1:0]     green_out,
    input  logic [bbc_pkg::CHAN_W-1:0]     blue_out,
    input  logic                           frame_end,
    output int                             mismatches,
    output int                             outstanding
);

    import bbc_pkg::*;

    localparam int ROW_PIXELS   = DEF_MAX_ROW_PIXELS;
    localparam int REPORT_LIMIT = 10;

    logic [PIX_W-1:0]       older_line  [ROW_PIXELS];
    logic [PIX_W-1:0]       recent_line [ROW_PIXELS];
    logic [PIX_W-1:0]       window      [3][3];
    logic [WIDTH_REG_W-1:0] width_reg;
    logic [HEIGHT_W-1:0]    height_reg;
    int unsigned            in_col;
    int unsigned            in_row;
    int unsigned            out_col;
    int unsigned            out_row;
    result_t                expected_pixels [$];
    result_t                got;
    result_t                want;
    int                     fail_count;
    logic                   ready;
    logic                   emitted;
    int unsigned            shifts;

    function automatic int unsigned row_width();
        if (width_reg == '0)
            return 1;
        if (width_reg > ROW_PIXELS)
            return ROW_PIXELS;
        return width_reg;
    endfunction

    function automatic int unsigned frame_height();
        return (height_reg == '0) ? 1 : height_reg;
    endfunction

    function automatic logic window_complete();
        return (in_row >= 2) || (in_row == 1 && in_col >= 1);
    endfunction

    function automatic void restart_position();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic string show_pixel(input result_t p);
        return $sformatf("r=%0d g=%0d b=%0d end=%0b", p.red, p.green, p.blue, p.frame_end);
    endfunction

    function automatic void shift_pixel(input logic [PIX_W-1:0] pix, input int unsigned w);
        int unsigned c;
        c = (in_col < ROW_PIXELS) ? in_col : ROW_PIXELS - 1;
        for (int i = 0; i < 3; i++)
        begin
            window[i][0] = window[i][1];
            window[i][1] = window[i][2];
        end
        window[0][2]   = older_line[c];
        window[1][2]   = recent_line[c];
        window[2][2]   = pix;
        older_line[c]  = recent_line[c];
        recent_line[c] = pix;
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
    endfunction

    // Mean over the in-frame part of the neighbourhood, rounded half up.
    function automatic result_t blur_pixel(input int unsigned w, input int unsigned h);
        int unsigned sr;
        int unsigned sg;
        int unsigned sb;
        int unsigned n;
        int unsigned r;
        int unsigned c;
        result_t     res;
        sr = 0;
        sg = 0;
        sb = 0;
        n  = 0;
        for (int i = 0; i < 3; i++)
        begin
            r = out_row + i;
            if (r >= 1 && r <= h)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    c = out_col + j;
                    if (c >= 1 && c <= w)
                    begin
                        sr += window[i][j][23:16];
                        sg += window[i][j][15:8];
                        sb += window[i][j][7:0];
                        n++;
                    end
                end
            end
        end
        if (n == 0)
            n = 1;
        res.red       = CHAN_W'((2 * sr + n) / (2 * n));
        res.green     = CHAN_W'((2 * sg + n) / (2 * n));
        res.blue      = CHAN_W'((2 * sb + n) / (2 * n));
        res.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
        if (res.frame_end)
            restart_position();
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = RESET_IMAGE_WIDTH;
            height_reg = RESET_IMAGE_HEIGHT;
            for (int i = 0; i < ROW_PIXELS; i++)
            begin
                older_line[i]  = '0;
                recent_line[i] = '0;
            end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    window[i][j] = '0;
            restart_position();
            expected_pixels.delete();
            fail_count = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                got.red       = red_out;
                got.green     = green_out;
                got.blue      = blue_out;
                got.frame_end = frame_end;
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected item: %s", show_pixel(got));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("mismatch: expected %s, got %s",
                                     show_pixel(want), show_pixel(got));
                    end
                end
            end

            if (cfg_write)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg = cfg_data[WIDTH_REG_W-1:0];
                else if (cfg_index == REG_IMAGE_HEIGHT)
                    height_reg = cfg_data[HEIGHT_W-1:0];
                restart_position();
            end

            if (push && !full)
            begin
                if (cmd == CMD_PIXEL)
                begin
                    if (in_row < frame_height())
                    begin
                        ready = window_complete();
                        shift_pixel({red_in, green_in, blue_in}, row_width());
                        if (ready)
                            expected_pixels.push_back(blur_pixel(row_width(), frame_height()));
                    end
                end
                else if (in_row >= frame_height())
                begin
                    // A single-row frame needs up to three shifts before its first output.
                    emitted = 1'b0;
                    shifts  = 0;
                    while (!emitted && shifts < 3)
                    begin
                        ready = window_complete();
                        shift_pixel('0, row_width());
                        if (ready)
                        begin
                            expected_pixels.push_back(blur_pixel(row_width(), frame_height()));
                            emitted = 1'b1;
                        end
                        shifts++;
                    end
                end
            end

            mismatches  <= fail_count;
            outstanding <= expected_pixels.size();
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Top of the box blur testbench: clock, reset, register writes, pixel and drain stimulus, verdict.
module tb;
    import bbc_pkg::*;

    localparam int RANDOM_ITEMS  = 750;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_GAP       = 40;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  push      = 1'b0;
    logic                  cmd       = CMD_PIXEL;
    logic [CHAN_W-1:0]     red_in    = '0;
    logic [CHAN_W-1:0]     green_in  = '0;
    logic [CHAN_W-1:0]     blue_in   = '0;
    logic                  pop       = 1'b0;
    logic                  full;
    logic                  empty;
    logic [CHAN_W-1:0]     red_out;
    logic [CHAN_W-1:0]     green_out;
    logic [CHAN_W-1:0]     blue_out;
    logic                  frame_end;
    int                    mismatches;
    int                    outstanding;

    int gap_pct   = 0;
    int stall_pct = 0;
    int phase     = 0;
    int random_items;
    int frame_w;
    int frame_h;

    always #2 clk = ~clk;

    box_blur_3x3_border_aware_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .empty     (empty),
        .pop       (pop),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end)
    );

    box_blur_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .empty       (empty),
        .pop         (pop),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .frame_end   (frame_end),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk)
        pop <= ($urandom_range(99) >= stall_pct);

    function automatic logic [CHAN_W-1:0] pick_channel();
        int unsigned k;
        k = $urandom_range(7);
        if (k == 0)
            return '0;
        if (k == 1)
            return '1;
        return CHAN_W'($urandom_range(255));
    endfunction

    function automatic int eff_width(input int w);
        if (w == 0)
            return 1;
        return (w > DEF_MAX_ROW_PIXELS) ? DEF_MAX_ROW_PIXELS : w;
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                gap_pct   = 0;
                stall_pct <= 0;
            end
            1:
            begin
                gap_pct   = 68;
                stall_pct <= 0;
            end
            2:
            begin
                gap_pct   = 0;
                stall_pct <= 68;
            end
            default:
            begin
                gap_pct   = 14;
                stall_pct <= 14;
            end
        endcase
    endtask

    task automatic send_item(input logic c, input logic [CHAN_W-1:0] r,
                             input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
        int idle;
        idle = 0;
        while (idle < MAX_GAP && $urandom_range(99) < gap_pct)
            idle++;
        if (idle > 0)
        begin
            push <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        push     <= 1'b1;
        cmd      <= c;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_pixel();
        send_item(CMD_PIXEL, pick_channel(), pick_channel(), pick_channel());
    endtask

    task automatic send_drain();
        send_item(CMD_DRAIN, pick_channel(), pick_channel(), pick_channel());
    endtask

    // Hold the input until every owed result has come out and the pipeline is quiet.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic config_frame(input logic [WIDTH_REG_W-1:0] w, input logic [HEIGHT_W-1:0] h);
        cfg_write <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= {5'($urandom_range(31)), w};
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_frame(input int w, input int h, input logic noisy, output int items);
        int ew;
        int eh;
        int drains;
        settle();
        config_frame(WIDTH_REG_W'(w), HEIGHT_W'(h));
        ew     = eff_width(w);
        eh     = (h == 0) ? 1 : h;
        drains = (eh == 1) ? ew : ew + 1;
        items  = ew * eh + drains;
        for (int p = 0; p < ew * eh; p++)
        begin
            send_pixel();
            if (noisy && p < ew * eh - 1 && $urandom_range(11) == 0)
                send_drain();
        end
        for (int i = 0; i < drains; i++)
        begin
            send_drain();
            if (noisy && i < drains - 1 && $urandom_range(9) == 0)
                send_pixel();
        end
        if (noisy && $urandom_range(3) == 0)
            send_drain();
    endtask

    task automatic partial_frame(input int w, input int h, input int count);
        settle();
        config_frame(WIDTH_REG_W'(w), HEIGHT_W'(h));
        repeat (count) send_pixel();
    endtask

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two by two frame with a stray drain mid-frame and a stray pixel while results are owed.
        config_frame(11'd2, 16'd2);
        send_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_item(CMD_DRAIN, 8'h00, 8'h00, 8'h00);
        send_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
        send_item(CMD_PIXEL, 8'hAA, 8'h55, 8'hFF);
        send_item(CMD_PIXEL, 8'h55, 8'hAA, 8'h00);
        send_item(CMD_DRAIN, 8'hFF, 8'hFF, 8'hFF);
        send_item(CMD_PIXEL, 8'h12, 8'h34, 8'h56);
        send_item(CMD_DRAIN, 8'h00, 8'h00, 8'h00);
        send_item(CMD_DRAIN, 8'h00, 8'h00, 8'h00);
        send_item(CMD_DRAIN, 8'h00, 8'h00, 8'h00);

        // A zero width acts as one pixel; a single-row frame drains with one tick per pixel.
        settle();
        config_frame(11'd0, 16'd1);
        send_item(CMD_PIXEL, 8'hFF, 8'h00, 8'h80);
        send_item(CMD_DRAIN, 8'h00, 8'h00, 8'h00);

        // A zero height acts as one row.
        settle();
        config_frame(11'd3, 16'd0);
        send_item(CMD_PIXEL, 8'h01, 8'hFE, 8'h7F);
        send_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'h00);
        send_item(CMD_PIXEL, 8'h00, 8'h01, 8'hFF);
        repeat (3) send_item(CMD_DRAIN, 8'h00, 8'h00, 8'h00);

        // An over-wide row setting acts as the widest row; the tallest frame is cut off early
        // in row one, after the first results of row zero.
        set_idling(1);
        partial_frame(2047, 65535, 1027);

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            int k;
            int n;
            phase = (phase + 1) % 4;
            set_idling(phase);
            k = $urandom_range(15);
            frame_w = (k == 0) ? 0 : (k <= 2) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            k = $urandom_range(15);
            frame_h = (k == 0) ? 0 : (k == 1) ? $urandom_range(6, 9) : $urandom_range(1, 4);
            run_frame(frame_w, frame_h, ($urandom_range(3) == 0), n);
            random_items += n;
        end

        settle();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
